[hw/rtl/dlle_pkg.sv]
package dlle_pkg;

  localparam int unsigned DLLE_CAPACITY  = 64;
  localparam int unsigned DLLE_KEY_WIDTH = 32;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IO_KEY_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_FRONT = 3'd0,
    OP_DELETE_KEY   = 3'd1,
    OP_DELETE_FIRST = 3'd2,
    OP_DELETE_LAST  = 3'd3,
    OP_DUMP         = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LINK,
    S_UNLINK,
    S_WALK,
    S_REPLY
  } state_e;

endpackage

[hw/rtl/dlle_if.sv]
interface dlle_in_if;
  import dlle_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [IO_KEY_W-1:0] key;

  modport source (output valid, operation, key, input ready);
  modport sink   (input valid, operation, key, output ready);
endinterface

interface dlle_out_if;
  import dlle_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [IO_KEY_W-1:0] key_out;
  logic                       last;

  modport source (output valid, status, key_out, last, input ready);
  modport sink   (input valid, status, key_out, last, output ready);
endinterface

[hw/rtl/dlle_pool.sv]
module dlle_pool #(
  parameter int unsigned CAPACITY  = dlle_pkg::DLLE_CAPACITY,
  parameter int unsigned KEY_WIDTH = dlle_pkg::DLLE_KEY_WIDTH,
  parameter type         req_t     = logic,
  parameter type         rsp_t     = logic
) (
  input  logic clk_i,
  input  req_t req_i,
  output rsp_t rsp_o
);
  import dlle_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] key_mem  [CAPACITY];
  logic [IW-1:0]        next_mem [CAPACITY];
  logic [IW-1:0]        prev_mem [CAPACITY];

  logic [KEY_WIDTH-1:0] key_rd_q;
  logic [IW-1:0]        next_rd_q;
  logic [IW-1:0]        prev_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem[req_i.key_addr] <= req_i.key_data;
    end
    key_rd_q <= key_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.next_we) begin
      next_mem[req_i.next_addr] <= req_i.next_data;
    end
    next_rd_q <= next_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.prev_we) begin
      prev_mem[req_i.prev_addr] <= req_i.prev_data;
    end
    prev_rd_q <= prev_mem[req_i.rd_addr];
  end

  always_comb begin
    rsp_o.key  = key_rd_q;
    rsp_o.next = next_rd_q;
    rsp_o.prev = prev_rd_q;
  end

endmodule

[hw/rtl/doubly_linked_list_engine_core.sv]
// channel  | dir | role   | payload
// in_i     | in  | sink   | operation, key
// out_o    | out | source | status, key_out, last
//
// one item at a time; in_i.ready is high only between items
// insert: scans from slot 0 for the lowest free slot and links it at the front; full pool: ST_FULL
// delete first/last: no walk; delete or dump on an empty list: ST_EMPTY with no pool read
// delete by key: walks from the head until the key matches, then unlinks; ST_NOT_FOUND when not
// dump: one beat per node, one node per cycle while out_o is not stalled; pool has one registered read port
// reset clears used bits, head and tail at once; no clearing pass
// out_o not ready stalls the dump walk and the final reply; one result buffered
module doubly_linked_list_engine_core #(
  parameter int unsigned CAPACITY  = dlle_pkg::DLLE_CAPACITY,
  parameter int unsigned KEY_WIDTH = dlle_pkg::DLLE_KEY_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlle_in_if.sink    in_i,
  dlle_out_if.source out_o
);
  import dlle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NoneIdx  = IW'(CAPACITY);
  localparam logic [IW-1:0] LastStep = IW'(CAPACITY - 1);

  typedef struct packed {
    logic [AW-1:0]        rd_addr;
    logic                 key_we;
    logic [AW-1:0]        key_addr;
    logic [KEY_WIDTH-1:0] key_data;
    logic                 next_we;
    logic [AW-1:0]        next_addr;
    logic [IW-1:0]        next_data;
    logic                 prev_we;
    logic [AW-1:0]        prev_addr;
    logic [IW-1:0]        prev_data;
  } pool_req_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [IW-1:0]        next;
    logic [IW-1:0]        prev;
  } pool_rsp_t;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [IW-1:0]        cur_q, cur_d;
  logic [IW-1:0]        steps_q, steps_d;
  status_e              status_q, status_d;
  logic [IW-1:0]        head_q, head_d;
  logic [IW-1:0]        tail_q, tail_d;
  logic [CAPACITY-1:0]  used_q, used_d;

  logic                       out_valid_q;
  logic [STATUS_W-1:0]        out_status_q;
  logic signed [IO_KEY_W-1:0] out_key_q;
  logic                       out_last_q;

  logic                       slot_free;
  logic                       emit;
  status_e                    emit_status;
  logic signed [IO_KEY_W-1:0] emit_key;
  logic                       emit_last;
  logic                       in_fire;
  logic [IW-1:0]              end_idx;

  pool_req_t pool_req;
  pool_rsp_t pool_rsp;

  dlle_pool #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .req_t     (pool_req_t),
    .rsp_t     (pool_rsp_t)
  ) u_pool (
    .clk_i (clk_i),
    .req_i (pool_req),
    .rsp_o (pool_rsp)
  );

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    status_d    = status_q;
    head_d      = head_q;
    tail_d      = tail_q;
    used_d      = used_q;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_key    = '0;
    emit_last   = 1'b1;
    end_idx     = head_q;

    pool_req           = '0;
    pool_req.rd_addr   = cur_q[AW-1:0];
    pool_req.key_addr  = cur_q[AW-1:0];
    pool_req.key_data  = key_q;
    pool_req.next_addr = cur_q[AW-1:0];
    pool_req.prev_addr = cur_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d  = op_e'(in_i.operation);
          key_d = KEY_WIDTH'(in_i.key);
          case (op_e'(in_i.operation))
            OP_INSERT_FRONT: begin
              cur_d   = '0;
              state_d = S_SCAN;
            end
            OP_DELETE_KEY, OP_DUMP, OP_DELETE_FIRST, OP_DELETE_LAST: begin
              if (op_e'(in_i.operation) == OP_DELETE_LAST) begin
                end_idx = tail_q;
              end
              if (head_q == NoneIdx) begin
                status_d = ST_EMPTY;
                state_d  = S_REPLY;
              end else begin
                cur_d            = end_idx;
                steps_d          = '0;
                pool_req.rd_addr = end_idx[AW-1:0];
                if (op_e'(in_i.operation) == OP_DELETE_KEY ||
                    op_e'(in_i.operation) == OP_DUMP) begin
                  state_d = S_WALK;
                end else begin
                  state_d = S_UNLINK;
                end
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cur_q == NoneIdx) begin
          status_d = ST_FULL;
          state_d  = S_REPLY;
        end else if (!used_q[cur_q[AW-1:0]]) begin
          pool_req.key_we    = 1'b1;
          pool_req.next_we   = 1'b1;
          pool_req.next_data = head_q;
          pool_req.prev_we   = 1'b1;
          pool_req.prev_data = NoneIdx;
          state_d            = S_LINK;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end

      S_LINK: begin
        if (head_q != NoneIdx) begin
          pool_req.prev_we   = 1'b1;
          pool_req.prev_addr = head_q[AW-1:0];
          pool_req.prev_data = cur_q;
        end else begin
          tail_d = cur_q;
        end
        head_d                 = cur_q;
        used_d[cur_q[AW-1:0]]  = 1'b1;
        status_d               = ST_OK;
        state_d                = S_REPLY;
      end

      S_UNLINK: begin
        if (pool_rsp.prev != NoneIdx) begin
          pool_req.next_we   = 1'b1;
          pool_req.next_addr = pool_rsp.prev[AW-1:0];
          pool_req.next_data = pool_rsp.next;
        end else begin
          head_d = pool_rsp.next;
        end
        if (pool_rsp.next != NoneIdx) begin
          pool_req.prev_we   = 1'b1;
          pool_req.prev_addr = pool_rsp.next[AW-1:0];
          pool_req.prev_data = pool_rsp.prev;
        end else begin
          tail_d = pool_rsp.prev;
        end
        used_d[cur_q[AW-1:0]] = 1'b0;
        status_d              = ST_OK;
        state_d               = S_REPLY;
      end

      S_WALK: begin
        if (op_q == OP_DELETE_KEY) begin
          if (pool_rsp.key == key_q) begin
            state_d = S_UNLINK;
          end else if (pool_rsp.next == NoneIdx || steps_q == LastStep) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_REPLY;
          end else begin
            cur_d            = pool_rsp.next;
            steps_d          = steps_q + 1'b1;
            pool_req.rd_addr = pool_rsp.next[AW-1:0];
          end
        end else if (slot_free) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_key    = IO_KEY_W'(signed'(pool_rsp.key));
          emit_last   = (pool_rsp.next == NoneIdx) || (steps_q == LastStep);
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            cur_d            = pool_rsp.next;
            steps_d          = steps_q + 1'b1;
            pool_req.rd_addr = pool_rsp.next[AW-1:0];
          end
        end
      end

      S_REPLY: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = status_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NoneIdx;
      tail_q      <= NoneIdx;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      used_q  <= used_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    status_q <= status_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_key_q    <= emit_key;
      out_last_q   <= emit_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.key_out = out_key_q;
  assign out_o.last    = out_last_q;

endmodule

[hw/rtl/dlle_checker.sv]
module dlle_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic [dlle_pkg::OP_W-1:0]            in_operation_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [dlle_pkg::STATUS_W-1:0]        out_status_i,
  input logic signed [dlle_pkg::IO_KEY_W-1:0] out_key_out_i,
  input logic                                 out_last_i
);
  import dlle_pkg::*;

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_key_out_i) && $stable(out_last_i))
    else $error("held result beat changed");

  // a defined operation takes the block out of idle, so ready drops after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i <= OP_DUMP) |=> !in_ready_i)
    else $error("ready after accepting an operation");

  // only dump beats run on without last, and they are ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == ST_OK)
    else $error("non-final beat with error status");

  // an error status is a lone beat with zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_last_i && out_key_out_i == '0)
    else $error("error beat not final or key nonzero");

  // no new item while an earlier one still has beats pending in the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a dump");

endmodule

bind doubly_linked_list_engine_core dlle_checker u_dlle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_key_out_i  (out_o.key_out),
  .out_last_i     (out_o.last)
);

[bench/dlle_list_checker.sv]
module dlle_list_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dlle_in_if   in_mon,
  dlle_out_if  out_mon,
  output int   err_count_o,
  output int   pending_o,
  output int   list_size_o
);
  import dlle_pkg::*;

  localparam int NIL = DLLE_CAPACITY;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IO_KEY_W-1:0] key_out;
    logic                last;
  } reply_t;

  logic signed [DLLE_KEY_WIDTH-1:0] slot_key  [DLLE_CAPACITY];
  int                               slot_next [DLLE_CAPACITY];
  int                               slot_prev [DLLE_CAPACITY];
  bit                               slot_used [DLLE_CAPACITY];
  int                               head_slot;
  int                               tail_slot;
  int                               live_nodes;

  reply_t awaited_replies [$];
  int     mismatches;

  function automatic void queue_reply(status_e st, logic [IO_KEY_W-1:0] k, logic fin);
    reply_t r;
    r.status  = st;
    r.key_out = k;
    r.last    = fin;
    awaited_replies.push_back(r);
  endfunction

  function automatic void unlink_slot(int i);
    int p;
    int n;
    p = slot_prev[i];
    n = slot_next[i];
    if (p != NIL) slot_next[p] = n;
    else head_slot = n;
    if (n != NIL) slot_prev[n] = p;
    else tail_slot = p;
    slot_used[i] = 1'b0;
    if (live_nodes > 0) live_nodes--;
  endfunction

  function automatic void apply_list_op(logic [OP_W-1:0] op, logic signed [IO_KEY_W-1:0] key_in);
    logic signed [DLLE_KEY_WIDTH-1:0] k;
    int i;
    int n;
    bit hit;
    k = DLLE_KEY_WIDTH'(key_in);
    case (op)
      OP_INSERT_FRONT: begin
        i = 0;
        while (i < NIL && slot_used[i]) i++;
        if (i == NIL) begin
          queue_reply(ST_FULL, '0, 1'b1);
        end else begin
          slot_used[i] = 1'b1;
          slot_key[i]  = k;
          slot_prev[i] = NIL;
          slot_next[i] = head_slot;
          if (head_slot != NIL) slot_prev[head_slot] = i;
          else tail_slot = i;
          head_slot = i;
          live_nodes++;
          queue_reply(ST_OK, '0, 1'b1);
        end
      end
      OP_DELETE_KEY: begin
        if (head_slot == NIL) begin
          queue_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          i   = head_slot;
          n   = 0;
          hit = 1'b0;
          while (!hit && i != NIL && n < NIL) begin
            if (slot_key[i] == k) hit = 1'b1;
            else begin
              i = slot_next[i];
              n++;
            end
          end
          if (hit) begin
            unlink_slot(i);
            queue_reply(ST_OK, '0, 1'b1);
          end else begin
            queue_reply(ST_NOT_FOUND, '0, 1'b1);
          end
        end
      end
      OP_DELETE_FIRST, OP_DELETE_LAST: begin
        if (head_slot == NIL) begin
          queue_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          unlink_slot(op == OP_DELETE_FIRST ? head_slot : tail_slot);
          queue_reply(ST_OK, '0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (head_slot == NIL) begin
          queue_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          i = head_slot;
          n = 0;
          while (n < NIL && i != NIL) begin
            queue_reply(ST_OK, IO_KEY_W'(slot_key[i]), (slot_next[i] == NIL) || (n + 1 >= NIL));
            n++;
            i = slot_next[i];
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int s = 0; s < DLLE_CAPACITY; s++) slot_used[s] = 1'b0;
      head_slot   = NIL;
      tail_slot   = NIL;
      live_nodes  = 0;
      mismatches  = 0;
      awaited_replies.delete();
      err_count_o <= 0;
      pending_o   <= 0;
      list_size_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected reply beat: status %0d key_out %0d last %0d",
                 out_mon.status, out_mon.key_out, out_mon.last);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            mismatches++;
          end
          if (out_mon.key_out !== want.key_out) begin
            $error("key_out: expected %0d, got %0d", $signed(want.key_out), out_mon.key_out);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_mon.last);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) apply_list_op(in_mon.operation, in_mon.key);
      err_count_o <= mismatches;
      pending_o   <= awaited_replies.size();
      list_size_o <= live_nodes;
    end
  end

endmodule

[bench/tb_doubly_linked_list_engine_core.sv]
module tb_doubly_linked_list_engine_core;
  import dlle_pkg::*;

  localparam int RANDOM_ITEMS   = 320;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int POOL_KEYS      = 12;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  dlle_in_if  in_if ();
  dlle_out_if out_if ();

  int err_count;
  int pending;
  int list_size;

  doubly_linked_list_engine_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dlle_list_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .err_count_o (err_count),
    .pending_o   (pending),
    .list_size_o (list_size)
  );

  logic signed [IO_KEY_W-1:0] key_pool [POOL_KEYS];
  int calm_in   = 0;
  int calm_out  = 0;
  int rd_stall  = 0;

  // reply side backpressure, with occasional stretches of none
  always @(posedge clk_i) begin
    int hold;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      if (calm_out > 0) begin
        calm_out = calm_out - 1;
        hold     = 0;
      end else begin
        hold = $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) calm_out = $urandom_range(10, 40);
      end
      rd_stall = hold;
      out_if.ready <= (hold == 0);
    end else if (rd_stall > 0) begin
      rd_stall = rd_stall - 1;
      out_if.ready <= (rd_stall == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic signed [IO_KEY_W-1:0] key);
    int gap;
    if (calm_in > 0) begin
      calm_in--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) calm_in = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.key       <= key;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_replies();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [IO_KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_KEYS - 1)];
    return $urandom();
  endfunction

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int  sent;
    int  r;
    bit  growing;
    logic [OP_W-1:0] op;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_INSERT_FRONT;
    in_if.key       <= '0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = $urandom();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list corner cases and undefined codes
    send_item(OP_DUMP, 32'h0);
    send_item(OP_DELETE_FIRST, 32'h0);
    send_item(OP_DELETE_LAST, 32'h0);
    send_item(OP_DELETE_KEY, 32'h7FFF_FFFF);
    send_item(OP_W'(5), 32'hFFFF_FFFF);
    send_item(OP_W'(6), 32'h0);
    send_item(OP_W'(7), 32'h8000_0000);

    send_item(OP_INSERT_FRONT, 32'h8000_0000);
    send_item(OP_INSERT_FRONT, 32'h7FFF_FFFF);
    send_item(OP_INSERT_FRONT, 32'h0000_0000);
    send_item(OP_INSERT_FRONT, 32'hFFFF_FFFF);
    send_item(OP_INSERT_FRONT, 32'h5555_5555);
    send_item(OP_INSERT_FRONT, 32'hAAAA_AAAA);
    send_item(OP_DUMP, 32'hFFFF_FFFF);
    send_item(OP_DELETE_KEY, 32'd12345);
    send_item(OP_DELETE_KEY, 32'h0000_0000);
    send_item(OP_DELETE_KEY, 32'h8000_0000);
    send_item(OP_DELETE_FIRST, 32'h0);
    send_item(OP_DELETE_LAST, 32'h0);
    send_item(OP_DUMP, 32'h0);
    // duplicate keys: only the front copy goes
    send_item(OP_INSERT_FRONT, 32'd7);
    send_item(OP_INSERT_FRONT, 32'd7);
    send_item(OP_DELETE_KEY, 32'd7);
    send_item(OP_DUMP, 32'h0);
    drain_replies();

    sent    = 0;
    growing = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent > 0 && sent % 50 == 0) drain_replies();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(OP_W'($urandom_range(5, 7)), $urandom());
        continue;
      end
      if (growing && list_size >= DLLE_CAPACITY) begin
        // overflow the pool, then show it whole
        repeat (3) send_item(OP_INSERT_FRONT, pick_key());
        send_item(OP_DUMP, $urandom());
        sent += 4;
        growing = 1'b0;
        continue;
      end
      if (!growing && list_size == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 72)      op = OP_INSERT_FRONT;
        else if (r < 84) op = OP_DELETE_KEY;
        else if (r < 90) op = OP_DELETE_FIRST;
        else if (r < 96) op = OP_DELETE_LAST;
        else             op = OP_DUMP;
      end else begin
        if (r < 20)      op = OP_INSERT_FRONT;
        else if (r < 50) op = OP_DELETE_KEY;
        else if (r < 71) op = OP_DELETE_FIRST;
        else if (r < 92) op = OP_DELETE_LAST;
        else             op = OP_DUMP;
      end
      send_item(op, (op == OP_INSERT_FRONT || op == OP_DELETE_KEY) ? pick_key() : $urandom());
      sent++;
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dlle_pkg.sv
hw/rtl/dlle_if.sv
hw/rtl/dlle_pool.sv
hw/rtl/doubly_linked_list_engine_core.sv
hw/rtl/dlle_checker.sv
bench/dlle_list_checker.sv
bench/tb_doubly_linked_list_engine_core.sv
